/* hdl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge while reset is released
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// property checked at every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

/* hdl/cwd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwd_pkg
// Types and constants of the crc-checked word deframer.
// ----------------------------------------------------------------------------
package cwd_pkg;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_TOP  = 8'h80;

    localparam int WORD_NUM_W = 5;

    // byte position inside a 3-byte word
    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_CHECK  = 2'd2;

    typedef struct packed {
        logic [15:0]           word_value;
        logic                  crc_mismatch;
        logic                  response_error;
        logic [WORD_NUM_W-1:0] word_number;
        logic                  pair_done;
        logic [31:0]           pair_value;
    } t_result;

endpackage

/* hdl/cwd_crc8.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwd_crc8
// One-byte update of the crc-8 (polynomial 0x31, msb first, no final xor).
// ----------------------------------------------------------------------------
module cwd_crc8 (
    input  logic [7:0] i_crc,
    input  logic [7:0] i_byte,
    output logic [7:0] o_crc
);

    logic [7:0] crc_work;

    always_comb begin
        crc_work = i_crc ^ i_byte;
        for (int k = 0; k < 8; k++) begin
            if ((crc_work & cwd_pkg::CRC_TOP) != 8'h00) begin
                crc_work = {crc_work[6:0], 1'b0} ^ cwd_pkg::CRC_POLY;
            end else begin
                crc_work = {crc_work[6:0], 1'b0};
            end
        end
        o_crc = crc_work;
    end

endmodule

/* hdl/cwd_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwd_tracker
// Response state: byte position, running crc, word pairing, sticky error and
// word count. Builds the result of a completed word in the same cycle.
// ----------------------------------------------------------------------------
module cwd_tracker #(
    parameter int MAX_WORDS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_first,
    input  logic [7:0]       i_byte,
    output logic             o_result_valid,
    output cwd_pkg::t_result o_result
);

    localparam int LIMIT_INT = (MAX_WORDS - 1 > 31) ? 31 : MAX_WORDS - 1;
    localparam logic [cwd_pkg::WORD_NUM_W-1:0] WORD_LIMIT =
        cwd_pkg::WORD_NUM_W'(LIMIT_INT);

    logic [1:0]                      r_pos,   n_pos;
    logic [7:0]                      r_hi,    n_hi;
    logic [7:0]                      r_lo,    n_lo;
    logic [7:0]                      r_crc,   n_crc;
    logic [15:0]                     r_upper, n_upper;
    logic                            r_odd,   n_odd;
    logic                            r_err,   n_err;
    logic [cwd_pkg::WORD_NUM_W-1:0]  r_count, n_count;

    logic [1:0]                      eff_pos;
    logic [15:0]                     eff_upper;
    logic                            eff_odd;
    logic                            eff_err;
    logic [cwd_pkg::WORD_NUM_W-1:0]  eff_count;
    logic [7:0]                      crc_seed;
    logic [7:0]                      crc_next;
    logic [15:0]                     word;
    logic                            mism;

    // a start flag clears the response state before the byte is taken
    always_comb begin
        eff_pos   = i_first ? cwd_pkg::POS_FIRST : r_pos;
        eff_upper = i_first ? 16'h0000 : r_upper;
        eff_odd   = i_first ? 1'b0 : r_odd;
        eff_err   = i_first ? 1'b0 : r_err;
        eff_count = i_first ? '0 : r_count;
        crc_seed  = (eff_pos == cwd_pkg::POS_SECOND) ? r_crc : cwd_pkg::CRC_INIT;
    end

    cwd_crc8 u_crc8 (
        .i_crc  (crc_seed),
        .i_byte (i_byte),
        .o_crc  (crc_next)
    );

    always_comb begin
        n_pos          = eff_pos;
        n_hi           = r_hi;
        n_lo           = r_lo;
        n_crc          = r_crc;
        n_upper        = eff_upper;
        n_odd          = eff_odd;
        n_err          = eff_err;
        n_count        = eff_count;
        word           = {r_hi, r_lo};
        mism           = (i_byte != r_crc);
        o_result_valid = 1'b0;
        o_result       = '0;
        case (eff_pos)
            cwd_pkg::POS_SECOND: begin
                n_crc = crc_next;
                n_lo  = i_byte;
                n_pos = cwd_pkg::POS_CHECK;
            end
            cwd_pkg::POS_CHECK: begin
                n_err   = eff_err | mism;
                n_count = (eff_count < WORD_LIMIT) ?
                          cwd_pkg::WORD_NUM_W'(eff_count + 1'b1) : eff_count;
                n_pos   = cwd_pkg::POS_FIRST;
                n_crc   = cwd_pkg::CRC_INIT;
                o_result_valid          = 1'b1;
                o_result.word_value     = word;
                o_result.crc_mismatch   = mism;
                o_result.response_error = eff_err | mism;
                o_result.word_number    = eff_count;
                if (eff_odd) begin
                    o_result.pair_done  = 1'b1;
                    o_result.pair_value = {eff_upper, word};
                    n_odd               = 1'b0;
                end else begin
                    n_upper = word;
                    n_odd   = 1'b1;
                end
            end
            default: begin
                // unused position code behaves as the first byte
                n_crc = crc_next;
                n_hi  = i_byte;
                n_pos = cwd_pkg::POS_SECOND;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= cwd_pkg::POS_FIRST;
            r_hi    <= 8'h00;
            r_lo    <= 8'h00;
            r_crc   <= cwd_pkg::CRC_INIT;
            r_upper <= 16'h0000;
            r_odd   <= 1'b0;
            r_err   <= 1'b0;
            r_count <= '0;
        end else if (i_en) begin
            r_pos   <= n_pos;
            r_hi    <= n_hi;
            r_lo    <= n_lo;
            r_crc   <= n_crc;
            r_upper <= n_upper;
            r_odd   <= n_odd;
            r_err   <= n_err;
            r_count <= n_count;
        end
    end

endmodule

/* hdl/crc_checked_word_deframer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_checked_word_deframer
// Splits a sensor response byte stream into crc-8 checked 16-bit words.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_stall) carries one byte per transfer with
// i_first_byte marking the start of a response. Every third byte of a
// response (the crc byte) yields one word on the output channel
// (o_valid / i_stall) with its crc check, a sticky response error flag, the
// saturating word index, and on every second word the 32-bit pair value.
// Data and partial words give no output word.
// Path: an accepted byte is held in the input register; the word it completes
// is then written into the output register, which drives o_valid.
// Throughput: one byte per cycle while the output is not stalled, set by the
// single-byte crc update that sits between the input and output registers.
// Reset clears both register stages and the response state (no word pending,
// crc seed 0xff). While the receiver stalls a held word, o_stall is raised
// and both stages hold; nothing is dropped.
// ----------------------------------------------------------------------------
module crc_checked_word_deframer #(
    parameter int MAX_WORDS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_first_byte,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_word_value,
    output logic        o_crc_mismatch,
    output logic        o_response_error,
    output logic [4:0]  o_word_number,
    output logic        o_pair_done,
    output logic [31:0] o_pair_value
);

    logic             advance;
    logic             r_in_valid;
    logic             r_in_first;
    logic [7:0]       r_in_byte;
    logic             r_out_valid;
    cwd_pkg::t_result r_out;
    logic             res_valid;
    cwd_pkg::t_result res;

    // whole pipe moves unless a held word is being stalled
    assign advance = !r_out_valid || !i_stall;
    assign o_stall = !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_in_valid  <= i_valid;
            r_out_valid <= r_in_valid && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_in_first <= i_first_byte;
            r_in_byte  <= i_data_byte;
        end
        if (advance && r_in_valid && res_valid) begin
            r_out <= res;
        end
    end

    cwd_tracker #(
        .MAX_WORDS (MAX_WORDS)
    ) u_tracker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (advance && r_in_valid),
        .i_first        (r_in_first),
        .i_byte         (r_in_byte),
        .o_result_valid (res_valid),
        .o_result       (res)
    );

    assign o_valid          = r_out_valid;
    assign o_word_value     = r_out.word_value;
    assign o_crc_mismatch   = r_out.crc_mismatch;
    assign o_response_error = r_out.response_error;
    assign o_word_number    = r_out.word_number;
    assign o_pair_done      = r_out.pair_done;
    assign o_pair_value     = r_out.pair_value;

endmodule

/* hdl/cwd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwd_checker
// Port-level checks of the crc-checked word deframer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cwd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [15:0] o_word_value,
    input logic        o_crc_mismatch,
    input logic        o_response_error,
    input logic        o_pair_done,
    input logic [31:0] o_pair_value
);

    // a stalled word stays put
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_word_value) && $stable(o_pair_value))

    // the block only pushes back while its own word is held
    `ASSERT_CLK(a_stall_cause, i_clk, i_rst_n, o_stall |-> o_valid && i_stall)

    // a mismatch always shows in the sticky flag
    `ASSERT_CLK(a_err_sticky, i_clk, i_rst_n, o_valid && o_crc_mismatch |-> o_response_error)

    // no pair value outside a completed pair
    `ASSERT_CLK(a_pair_zero, i_clk, i_rst_n, o_valid && !o_pair_done |-> o_pair_value == 32'h0)

    // reset empties the output stage
    `ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_valid)

endmodule

bind crc_checked_word_deframer cwd_checker u_cwd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_stall          (o_stall),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_word_value     (o_word_value),
    .o_crc_mismatch   (o_crc_mismatch),
    .o_response_error (o_response_error),
    .o_pair_done      (o_pair_done),
    .o_pair_value     (o_pair_value)
);
